// ===== hdl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median filter
// Holds the per-cell status struct that travels between neighbouring cells
// and the width and reset value of the window length register.
// ----------------------------------------------------------------------------
package smf_pkg;

  // width of the window length register as seen on the configuration port
  localparam int unsigned CfgLenBits = 5;

  // window length after reset
  localparam int unsigned LenReset = 5;

  // status a cell shows to its neighbours
  typedef struct packed {
    logic valid;  // cell holds a sample of the window
    logic gt;     // held sample is larger than the incoming one
    logic rem;    // held sample is the oldest and leaves with this item
    logic above;  // the leaving sample sits in a lower cell
  } smf_flags_t;

endpackage

// ===== hdl/sliding_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_median_filter_unit: running median over a window of samples
// Sorted chain of cells with age tags; the median is read from the middle
// cells into an output register after the chain is updated.
// ----------------------------------------------------------------------------
// A new sample is taken in every cycle while results are taken as they come:
// the chain of MAX_WINDOW cells inserts the sample and drops the oldest one
// in the same update, and the median of that window is then registered on
// the output, so one item per cycle is sustained.
// No result is given until window_len samples have arrived since reset or
// since the last write of window_len, which also empties the window. A
// window_len of 0 acts as 1 and one above MAX_WINDOW acts as MAX_WINDOW. For
// an even length the two middle samples are summed and shifted right by one.
// Input is stalled only while a finished result waits and the output is
// stalled too.
module sliding_median_filter_unit #(
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] median
  // window length register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smf_pkg::CfgLenBits-1:0]      cfg_data   // window_len
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned AGE_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LEN_RST = (smf_pkg::LenReset > MAX_WINDOW) ?
                                    MAX_WINDOW : smf_pkg::LenReset;

  logic                          step;
  logic                          out_free;
  logic                          cfg_write;
  logic        [LEN_W-1:0]       len;
  logic        [LEN_W-1:0]       len_next;
  logic        [LEN_W-1:0]       fill;
  logic        [LEN_W-1:0]       fill_after;
  logic                          full;
  logic                          pend;
  logic signed [SAMPLE_BITS-1:0] new_sample;
  logic        [SAMPLE_BITS-1:0] median;
  logic        [AGE_W-1:0]       idx_hi;
  logic        [AGE_W-1:0]       idx_lo;
  logic signed [SAMPLE_BITS:0]   mid_sum;
  logic        [MAX_WINDOW-1:0]  valid_vec;

  smf_pkg::smf_flags_t           cell_flags [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
  logic        [AGE_W-1:0]       cell_age   [MAX_WINDOW];

  // handshakes
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = !pend || out_free;
  assign step       = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign new_sample = s_tdata[SAMPLE_BITS-1:0];

  // effective window length from the written value
  always_comb begin
    if (cfg_data == '0) begin
      len_next = LEN_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
      len_next = LEN_W'(MAX_WINDOW);
    end else begin
      len_next = LEN_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(LEN_RST);
    end else if (cfg_write) begin
      len <= len_next;
    end
  end

  // fill count of the window
  assign full       = (fill == len);
  assign fill_after = full ? len : fill + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      fill <= '0;
    end else if (step) begin
      fill <= fill_after;
    end
  end

  // row of cells, sorted ascending from cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    smf_pkg::smf_flags_t           lf;
    smf_pkg::smf_flags_t           rf;
    logic signed [SAMPLE_BITS-1:0] lv;
    logic signed [SAMPLE_BITS-1:0] rv;
    logic        [AGE_W-1:0]       la;
    logic        [AGE_W-1:0]       ra;
    logic                          keep;

    if (i == 0) begin : g_first
      assign lf = '0;
      assign lv = '0;
      assign la = '0;
    end else begin : g_left
      assign lf = cell_flags[i-1];
      assign lv = cell_value[i-1];
      assign la = cell_age[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rf = '0;
      assign rv = '0;
      assign ra = '0;
    end else begin : g_right
      assign rf = cell_flags[i+1];
      assign rv = cell_value[i+1];
      assign ra = cell_age[i+1];
    end

    assign keep         = (32'(i) < 32'(fill_after));
    assign valid_vec[i] = cell_flags[i].valid;

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .clear       (cfg_write),
      .step        (step),
      .new_sample  (new_sample),
      .len         (len),
      .full        (full),
      .keep        (keep),
      .left_flags  (lf),
      .left_value  (lv),
      .left_age    (la),
      .right_flags (rf),
      .right_value (rv),
      .right_age   (ra),
      .flags       (cell_flags[i]),
      .value       (cell_value[i]),
      .age         (cell_age[i])
    );
  end

  // middle cells; for an odd length both picks are the same cell
  assign idx_hi  = AGE_W'(len >> 1);
  assign idx_lo  = len[0] ? idx_hi : idx_hi - AGE_W'(1);
  assign mid_sum = (SAMPLE_BITS+1)'(cell_value[idx_lo]) +
                   (SAMPLE_BITS+1)'(cell_value[idx_hi]);
  assign median  = mid_sum[SAMPLE_BITS:1];

  // result due from the last update of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (step) begin
      pend <= (fill_after == len);
    end else if (pend && out_free) begin
      pend <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  logic [SAMPLE_BITS-1:0] median_q;

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      median_q <= median;
    end
  end

  assign m_tdata = TDATA_W'(median_q);

`ifndef NO_ASSERTIONS
  // a due result is never dropped while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    pend && !out_free |=> pend)
    else $error("pending median lost");

  // the fill count never passes the window length
  assert property (@(posedge clk) disable iff (rst)
    fill <= len)
    else $error("fill count above window length");

  // occupied cells match the fill count
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("cell occupancy differs from fill count");

  // a result appears only from a pending median
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pend))
    else $error("result without pending median");
`endif

endmodule

// ===== hdl/smf_cell.sv =====
// ----------------------------------------------------------------------------
// smf_cell: one cell of the sorted sample chain
// Holds one sample and its age. On each accepted item the cell takes its
// next content from itself, from a neighbour or from the incoming sample so
// that the chain stays sorted in ascending order with the oldest sample
// dropped once the window is full.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned AGE_W       = 4,
  parameter int unsigned LEN_W       = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  input  logic        [LEN_W-1:0]       len,
  input  logic                          full,
  input  logic                          keep,
  input  smf_pkg::smf_flags_t           left_flags,
  input  logic signed [SAMPLE_BITS-1:0] left_value,
  input  logic        [AGE_W-1:0]       left_age,
  input  smf_pkg::smf_flags_t           right_flags,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  logic        [AGE_W-1:0]       right_age,
  output smf_pkg::smf_flags_t           flags,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic        [AGE_W-1:0]       age
);

  logic                          valid;
  logic                          rem;
  logic                          gt;
  logic                          above;
  logic                          from_right;
  logic                          from_left;
  logic                          from_self;
  logic signed [SAMPLE_BITS-1:0] value_next;
  logic        [AGE_W-1:0]       age_next;

  // status of this cell against the incoming sample
  assign rem   = valid && full && (LEN_W'(age) == len - LEN_W'(1));
  assign gt    = valid && !rem && (value > new_sample);
  assign above = left_flags.above || left_flags.rem;

  assign flags.valid = valid;
  assign flags.gt    = gt;
  assign flags.rem   = rem;
  assign flags.above = above;

  // source selection: removal pulls down, insertion pushes up
  assign from_right = right_flags.valid && right_flags.above && !right_flags.rem &&
                      !right_flags.gt;
  assign from_left  = left_flags.valid && !left_flags.above && !left_flags.rem &&
                      left_flags.gt;
  assign from_self  = valid && !rem && (gt == above);

  always_comb begin
    if (from_right) begin
      value_next = right_value;
      age_next   = right_age + AGE_W'(1);
    end else if (from_left) begin
      value_next = left_value;
      age_next   = left_age + AGE_W'(1);
    end else if (from_self) begin
      value_next = value;
      age_next   = age + AGE_W'(1);
    end else begin
      value_next = new_sample;
      age_next   = '0;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= keep;
    end
  end

  // sample and age
  always_ff @(posedge clk) begin
    if (step) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for sliding_median_filter_unit
// A directed table covers extreme samples, odd and even window lengths,
// length clamping and emptying of the window on a length write. Random
// phases then stream samples under many window lengths. Directed medians
// are checked against the table and random ones against a window model kept
// in the bench, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_WIN       = 16;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DIR_ROWS      = 25;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        typed;
    logic [15:0] median;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [15:0]                   s_tdata = '0;   // [15:0] sample
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;        // [15:0] median
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [smf_pkg::CfgLenBits-1:0] cfg_data = '0;

  // window model
  logic signed [15:0]             win_buf [MAX_WIN];
  int                             win_wr = 0;
  int                             win_fill = 0;
  logic [smf_pkg::CfgLenBits-1:0] win_len_reg = smf_pkg::CfgLenBits'(smf_pkg::LenReset);

  logic [15:0] median_q [$];
  dir_row_t    dir_rows [DIR_ROWS];
  logic [4:0]  len_plan [9] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd15, 5'd4, 5'd3, 5'd8};

  int  samples_sent = 0;
  int  medians_checked = 0;
  int  lengths_written = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  logic rx_calm = 1'b0;
  logic tx_calm = 1'b0;

  sliding_median_filter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample mix: extremes, clustered values for ties, full range
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    if (r < 40) return 16'($signed($urandom_range(0, 8)) - 4);
    return 16'($urandom);
  endfunction

  // push one sample into the window model, give the median if one is due
  function automatic bit window_median(input logic [15:0] raw, output logic [15:0] med);
    logic signed [15:0] srt [MAX_WIN];
    logic signed [15:0] v;
    logic signed [16:0] pair_sum;
    int n, pos, j;
    n = int'(win_len_reg);
    if (n == 0) n = 1;
    if (n > MAX_WIN) n = MAX_WIN;
    win_buf[win_wr] = raw;
    win_wr = (win_wr + 1) % MAX_WIN;
    if (win_fill < n) win_fill++;
    med = '0;
    if (win_fill < n) return 1'b0;
    // newest first, insertion sort
    pos = win_wr;
    for (int i = 0; i < n; i++) begin
      pos = (pos + MAX_WIN - 1) % MAX_WIN;
      v = win_buf[pos];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n % 2 == 1) begin
      med = srt[n/2];
    end else begin
      pair_sum = srt[n/2-1] + srt[n/2];
      med = pair_sum[16:1];
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t row_s(input logic [15:0] v);
    return '{kind: ROW_SAMPLE, value: v, typed: 1'b0, median: 16'h0};
  endfunction

  function automatic dir_row_t row_t(input logic [15:0] v, input logic [15:0] m);
    return '{kind: ROW_SAMPLE, value: v, typed: 1'b1, median: m};
  endfunction

  function automatic dir_row_t row_len(input logic [15:0] v);
    return '{kind: ROW_LEN, value: v, typed: 1'b0, median: 16'h0};
  endfunction

  // offer one sample, record its median once accepted
  task automatic send_sample(input logic [15:0] v, input int gap, input logic typed,
                             input logic [15:0] typed_med);
    logic [15:0] med;
    bit due;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(negedge clk); while (!s_tready);
    due = window_median(v, med);
    if (typed) median_q = {median_q, typed_med};
    else if (due) median_q = {median_q, med};
    samples_sent++;
    @(posedge clk);
  endtask

  // stop sending and wait for every outstanding median
  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // write the window length, which also empties the window
  task automatic write_len(input logic [smf_pkg::CfgLenBits-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    win_len_reg = v;
    win_wr = 0;
    win_fill = 0;
    lengths_written++;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      rx_hold  <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // median check, sampled mid-cycle
  always @(negedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (median_q.size() == 0) begin
        mismatches++;
        $display("%0t: median %h with none expected", $time, m_tdata);
      end else begin
        want = median_q.pop_front();
        medians_checked++;
        if (m_tdata !== want) begin
          mismatches++;
          $display("%0t: median expected %h actual %h", $time, want, m_tdata);
        end
      end
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL sliding_median_filter_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int n_items;
    logic [4:0] len;
    dir_rows = '{
      // reset length of five
      row_s(16'sd100), row_s(-16'sd200), row_s(16'sd300), row_s(-16'sd400),
      row_t(16'sd500, 16'sd100),
      // length one passes samples through
      row_len(16'd1),
      row_t(16'h8000, 16'h8000), row_t(16'h7fff, 16'h7fff),
      row_t(16'h0000, 16'h0000), row_t(16'hffff, 16'hffff),
      // length two, floor of the halved sum
      row_len(16'd2),
      row_s(16'h7fff), row_t(16'h7fff, 16'h7fff), row_t(16'h8000, 16'hffff),
      row_t(16'h8000, 16'h8000), row_t(16'h0000, 16'hc000), row_t(16'hffff, 16'hffff),
      // zero length acts as one
      row_len(16'd0),
      row_t(16'h1234, 16'h1234),
      // rewrite while part filled empties the window
      row_len(16'd3), row_s(16'sd9), row_len(16'd3),
      row_s(16'sd7), row_s(16'sd7), row_t(-16'sd5, 16'sd7)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_LEN) begin
        settle(SETTLE_CYCLES);
        write_len(dir_rows[k].value[4:0]);
      end else begin
        send_sample(dir_rows[k].value, 0, dir_rows[k].typed, dir_rows[k].median);
      end
    end

    // random phases, one window length each
    phase = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      len = (phase < 9) ? len_plan[phase] : 5'($urandom_range(0, 31));
      settle(SETTLE_CYCLES);
      write_len(len);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(10, 130);
      for (int k = 0; k < n_items; k++) begin
        // sender holds off until the pipeline has drained
        if (phase % 5 == 2 && k == n_items / 2) settle(0);
        send_sample(pick_sample(), tx_calm ? 0 : pick_gap(), 1'b0, 16'h0);
      end
      phase++;
    end

    settle(END_CYCLES);
    $display("covered %0d samples and %0d medians over %0d window length writes",
             samples_sent, medians_checked, lengths_written);
    $display("stalls on both streams, drained pauses, lengths 0 to 31 incl. clamped ones");
    if (mismatches == 0 && median_q.size() == 0) begin
      $display("PASS sliding_median_filter_unit");
    end else begin
      $display("FAIL sliding_median_filter_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/smf_pkg.sv
hdl/smf_cell.sv
hdl/sliding_median_filter_unit.sv
tb/sv/tb.sv
